// ===== sv/spfr_pkg.sv =====
package spfr_pkg;

    // Start pattern characters and the count that stands after a match.
    localparam logic [7:0] CH_DOLLAR   = 8'h24;
    localparam logic [7:0] CH_K        = 8'h4B;
    localparam logic [7:0] CH_A        = 8'h41;
    localparam logic [7:0] PATTERN_LEN = 8'd3;

    // Configuration port widths and register indexes.
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_LENGTH     = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAYLOAD_CAPACITY = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEPARATOR_CHAR   = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_END_CHAR         = 8'd3;

    // Reset values of the configuration registers.
    localparam logic [7:0] RST_FRAME_LENGTH     = 8'd14;
    localparam logic [7:0] RST_PAYLOAD_CAPACITY = 8'd4;
    localparam logic [7:0] RST_SEPARATOR_CHAR   = 8'd44;
    localparam logic [7:0] RST_END_CHAR         = 8'd42;

    // Current configuration as seen by the frame logic.
    typedef struct packed {
        logic [7:0] frame_length;
        logic [7:0] payload_capacity;
        logic [7:0] separator_char;
        logic [7:0] end_char;
    } t_cfg;

    // One result item.
    typedef struct packed {
        logic       write_enable;
        logic [7:0] write_index;
        logic [7:0] write_data;
        logic       frame_ready;
    } t_result;

endpackage

// ===== sv/start_pattern_frame_receiver_core.sv =====
// An accepted input item is held in the input register, then its result item is
// loaded into the result register, where it can be taken while o_out_valid is high.
// One item per cycle while the output is not stalled; the frame state updates once per item.
// Reset (i_rst_n low, synchronous) clears both stages, the frame state and
// loads the configuration defaults.
module start_pattern_frame_receiver_core
    import spfr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [7:0]             i_rx_byte,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_write_enable,
    output logic [7:0]             o_write_index,
    output logic [7:0]             o_write_data,
    output logic                   o_frame_ready
);

    t_cfg       cfg;
    t_result    result;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    logic       out_load;
    logic       advance;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    spfr_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Pipeline flow: the result register loads when empty or being drained.
    assign out_load   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_load;
    assign o_in_ready = !r_in_valid || advance;

    spfr_frame_ctrl u_frame_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_byte   (r_in_byte),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) r_in_valid <= i_in_valid;
            if (out_load) r_out_valid <= r_in_valid;
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) r_in_byte <= i_rx_byte;
        if (advance) r_out <= result;
    end

    assign o_out_valid    = r_out_valid;
    assign o_write_enable = r_out.write_enable;
    assign o_write_index  = r_out.write_index;
    assign o_write_data   = r_out.write_data;
    assign o_frame_ready  = r_out.frame_ready;

endmodule

// ===== sv/spfr_cfg_regs.sv =====
module spfr_cfg_regs
    import spfr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the register index; unknown indexes are ignored.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FRAME_LENGTH:     n_cfg.frame_length     = i_cfg_data;
                CFG_PAYLOAD_CAPACITY: n_cfg.payload_capacity = i_cfg_data;
                CFG_SEPARATOR_CHAR:   n_cfg.separator_char   = i_cfg_data;
                CFG_END_CHAR:         n_cfg.end_char         = i_cfg_data;
                default:              n_cfg = r_cfg;
            endcase
        end
    end

    // Register file with reset defaults.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_length     <= RST_FRAME_LENGTH;
            r_cfg.payload_capacity <= RST_PAYLOAD_CAPACITY;
            r_cfg.separator_char   <= RST_SEPARATOR_CHAR;
            r_cfg.end_char         <= RST_END_CHAR;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/spfr_frame_ctrl.sv =====
module spfr_frame_ctrl
    import spfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    typedef enum logic [1:0] {
        STEP_IDLE,
        STEP_DOLLAR,
        STEP_K
    } t_match_step;

    t_match_step r_step, n_step;
    logic        r_in_frame, n_in_frame;
    logic [7:0]  r_count, n_count;
    logic [7:0]  r_index, n_index;
    logic        hit;
    logic [7:0]  count_inc;

    // Start pattern matcher; a mismatch in later steps always returns to idle.
    always_comb begin
        hit = 1'b0;
        unique case (r_step)
            STEP_IDLE:   n_step = (i_byte == CH_DOLLAR) ? STEP_DOLLAR : STEP_IDLE;
            STEP_DOLLAR: n_step = (i_byte == CH_K) ? STEP_K : STEP_IDLE;
            STEP_K: begin
                n_step = STEP_IDLE;
                hit    = (i_byte == CH_A);
            end
            default:     n_step = STEP_IDLE;
        endcase
    end

    assign count_inc = r_count + 8'd1;

    // Frame tracking, payload write and close detection for one item.
    always_comb begin
        n_in_frame = r_in_frame;
        n_count    = r_count;
        n_index    = r_index;
        o_result   = '0;
        if (!r_in_frame) begin
            n_in_frame = hit;
            n_count    = PATTERN_LEN;
        end else if (hit) begin
            n_count = PATTERN_LEN;
            n_index = 8'd0;
        end else begin
            n_count = count_inc;
            if (i_byte != i_cfg.separator_char) begin
                if (r_index < i_cfg.payload_capacity) begin
                    o_result.write_enable = 1'b1;
                    o_result.write_index  = r_index;
                    o_result.write_data   = i_byte;
                end
                n_index = r_index + 8'd1;
            end
            if (count_inc == i_cfg.frame_length) begin
                n_in_frame           = 1'b0;
                n_index              = 8'd0;
                n_count              = 8'd0;
                o_result.frame_ready = (i_byte == i_cfg.end_char);
            end
        end
    end

    // State advances once per item taken from the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= STEP_IDLE;
            r_in_frame <= 1'b0;
            r_count    <= 8'd0;
            r_index    <= 8'd0;
        end else if (i_step) begin
            r_step     <= n_step;
            r_in_frame <= n_in_frame;
            r_count    <= n_count;
            r_index    <= n_index;
        end
    end

endmodule

// ===== sv/spfr_checker.sv =====
module spfr_checker
    import spfr_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_write_enable,
    input logic [7:0] o_write_index,
    input logic [7:0] o_write_data,
    input logic       o_frame_ready
);

    // An item without a write carries zero index and data.
    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_write_enable) |-> (o_write_index == 8'd0 && o_write_data == 8'd0))
        else $error("item without write has nonzero index or data");

    // No result is shown right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A stalled result item holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_write_enable)
            && $stable(o_write_index) && $stable(o_write_data) && $stable(o_frame_ready)))
        else $error("stalled result item changed");

    // A write index never reaches the top of its range.
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_write_enable) |-> (o_write_index != 8'hFF))
        else $error("write index out of range");

endmodule

bind start_pattern_frame_receiver_core spfr_checker u_spfr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_write_enable (o_write_enable),
    .o_write_index  (o_write_index),
    .o_write_data   (o_write_data),
    .o_frame_ready  (o_frame_ready)
);
